[hw/rtl/aeb_pkg.sv]
package aeb_pkg;

  // ALU operation codes
  localparam logic [2:0] CMD_CMP = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_OR  = 3'd2;
  localparam logic [2:0] CMD_AND = 3'd3;
  localparam logic [2:0] CMD_XOR = 3'd4;
  localparam logic [2:0] CMD_SHL = 3'd5;
  localparam logic [2:0] CMD_SHR = 3'd6;

  // Branch condition codes
  localparam logic [2:0] COND_ALWAYS = 3'd0;
  localparam logic [2:0] COND_EQ     = 3'd1;
  localparam logic [2:0] COND_NE     = 3'd2;
  localparam logic [2:0] COND_LT     = 3'd3;
  localparam logic [2:0] COND_GT     = 3'd4;
  localparam logic [2:0] COND_LE     = 3'd5;
  localparam logic [2:0] COND_GE     = 3'd6;

  localparam int unsigned XLEN = 32;
  localparam int unsigned SHW  = 5;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    logic [XLEN-1:0] op_c;
    logic [XLEN-1:0] pc;
    logic            signed_op;
    logic            shift_in_carry;
    logic            carry_update;
    logic            branch_on;
    logic [2:0]      condition;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0] alu_value;
    logic            taken;
    logic [XLEN-1:0] target;
    logic            carry_now;
    logic            bad_op;
  } out_item_t;

  // ALU status towards the stage control
  typedef struct packed {
    logic carry;     // carry produced by this operation
    logic carry_wr;  // operation writes the ALU carry latch
    logic bad;       // operation not allowed
  } alu_status_t;

endpackage

[hw/rtl/aeb_alu.sv]
module aeb_alu (
  input  aeb_pkg::in_item_t          item,
  input  logic                       status_carry,
  output logic [aeb_pkg::XLEN-1:0]   value,
  output aeb_pkg::alu_status_t       status
);
  import aeb_pkg::*;

  logic [XLEN+1:0] sum3;
  logic [XLEN:0]   diff;
  logic            lt;
  logic [SHW-1:0]  shamt;
  logic [XLEN-1:0] shr_val;
  logic [XLEN-1:0] low_mask;
  logic            fill;

  // Three-operand add and subtract for compare
  assign sum3 = {2'b00, item.op_a} + {2'b00, item.op_b} + {2'b00, item.op_c};
  assign diff = {1'b0, item.op_a} + {1'b0, ~item.op_b} + {{XLEN{1'b0}}, 1'b1};
  assign lt   = item.signed_op ? ($signed(item.op_a) < $signed(item.op_b))
                               : (item.op_a < item.op_b);

  // Right shift with selectable fill; carry when any lost bit is set
  assign shamt    = item.op_b[SHW-1:0];
  assign fill     = item.signed_op ? item.op_a[XLEN-1]
                                   : (item.shift_in_carry & status_carry);
  assign low_mask = ~({XLEN{1'b1}} << shamt);
  assign shr_val  = (item.op_a >> shamt) | ({XLEN{fill}} & ~({XLEN{1'b1}} >> shamt));

  always_comb begin
    value           = '0;
    status.carry    = 1'b0;
    status.carry_wr = 1'b0;
    status.bad      = 1'b0;
    case (item.cmd)
      CMD_CMP: begin
        value           = {lt, diff[XLEN-2:0]};
        status.carry    = diff[XLEN];
        status.carry_wr = 1'b1;
      end
      CMD_ADD: begin
        value           = sum3[XLEN-1:0];
        status.carry    = |sum3[XLEN+1:XLEN];
        status.carry_wr = 1'b1;
      end
      CMD_OR:  value = item.op_a | item.op_b;
      CMD_AND: value = item.op_a & item.op_b;
      CMD_XOR: value = item.op_a ^ item.op_b;
      CMD_SHL: value = item.op_a << shamt;
      CMD_SHR: begin
        if (item.signed_op && item.shift_in_carry) begin
          status.bad = 1'b1;
        end else begin
          value           = shr_val;
          status.carry    = |(item.op_a & low_mask);
          status.carry_wr = 1'b1;
        end
      end
      default: status.bad = 1'b1;
    endcase
  end

endmodule

[hw/rtl/aeb_branch.sv]
module aeb_branch (
  input  logic [aeb_pkg::XLEN-1:0] value,
  input  logic [aeb_pkg::XLEN-1:0] pc,
  input  logic [aeb_pkg::XLEN-1:0] offset,
  input  logic                     branch_on,
  input  logic [2:0]               condition,
  input  logic                     bad,
  output logic                     taken,
  output logic [aeb_pkg::XLEN-1:0] target
);
  import aeb_pkg::*;

  logic zero;
  logic neg;
  logic hit;

  assign zero = (value == '0);
  assign neg  = value[XLEN-1];

  // Condition decode on the ALU result flags
  always_comb begin
    case (condition)
      COND_ALWAYS: hit = 1'b1;
      COND_EQ:     hit = zero;
      COND_NE:     hit = !zero;
      COND_LT:     hit = neg;
      COND_GT:     hit = !zero && !neg;
      COND_LE:     hit = zero || neg;
      COND_GE:     hit = zero || !neg;
      default:     hit = 1'b0;
    endcase
  end

  assign taken  = hit && branch_on && !bad;
  assign target = !taken ? '0 : ((condition == COND_ALWAYS) ? value : pc + offset);

endmodule

[hw/rtl/alu_execute_branch_stage_top.sv]
// Execute stage: an accepted instruction item passes through the input register
// and then the result register before its result is on the output, with a
// sustained rate of one item per cycle while the result side does not stall.
// The ALU and branch decision are one combinational pass between the two
// registers; the status and ALU carry latches update as an item moves into the
// result register, so the next item sees them at once. A stall on the result
// side holds the input register, and in_ready falls only when both registers
// are full and out_ready is low.
module alu_execute_branch_stage_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aeb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output aeb_pkg::out_item_t out_item
);
  import aeb_pkg::*;

  in_item_t        item_r;
  logic            item_valid_r;
  out_item_t       res_r;
  logic            res_valid_r;
  logic            status_carry_r, status_carry_nxt;
  logic            last_carry_r, last_carry_nxt;
  logic            advance;
  logic [XLEN-1:0] alu_value;
  alu_status_t     alu_st;
  logic            taken;
  logic [XLEN-1:0] target;

  // Handshake: result slot free, input slot moves on
  assign advance   = !res_valid_r || out_ready;
  assign in_ready  = !item_valid_r || advance;
  assign out_valid = res_valid_r;
  assign out_item  = res_r;

  aeb_alu u_alu (
    .item         (item_r),
    .status_carry (status_carry_r),
    .value        (alu_value),
    .status       (alu_st)
  );

  aeb_branch u_branch (
    .value     (alu_value),
    .pc        (item_r.pc),
    .offset    (item_r.op_c),
    .branch_on (item_r.branch_on),
    .condition (item_r.condition),
    .bad       (alu_st.bad),
    .taken     (taken),
    .target    (target)
  );

  // Carry latches after this item
  always_comb begin
    last_carry_nxt   = last_carry_r;
    status_carry_nxt = status_carry_r;
    if (!alu_st.bad) begin
      if (alu_st.carry_wr) last_carry_nxt = alu_st.carry;
      if (item_r.carry_update) status_carry_nxt = last_carry_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
    if (in_valid && in_ready) item_r <= in_item;
  end

  // Result register and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r    <= 1'b0;
      status_carry_r <= 1'b0;
      last_carry_r   <= 1'b0;
    end else if (advance) begin
      res_valid_r <= item_valid_r;
      if (item_valid_r) begin
        status_carry_r <= status_carry_nxt;
        last_carry_r   <= last_carry_nxt;
      end
    end
    if (advance && item_valid_r) begin
      res_r.alu_value <= alu_value;
      res_r.taken     <= taken;
      res_r.target    <= target;
      res_r.carry_now <= status_carry_nxt;
      res_r.bad_op    <= alu_st.bad;
    end
  end

  // A rejected operation leaves no value and no branch
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.bad_op |-> !res_r.taken && res_r.alu_value == '0)
    else $error("bad operation produced a value or branch");

  // Carry latches only move when an item retires into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && item_valid_r) |=> $stable(status_carry_r) && $stable(last_carry_r))
    else $error("carry state changed without an item");

  // Reported carry matches the stored flag for the newest result
  a_carry_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_valid_r |=> res_r.carry_now == status_carry_r)
    else $error("carry_now differs from status carry");

  // A held result is not overwritten
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !out_ready |=> res_valid_r && $stable(res_r))
    else $error("stalled result changed");

  // Not-taken branches report a zero target
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.taken |-> res_r.target == '0)
    else $error("target set without a taken branch");

endmodule
